/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk with async rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MRQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("message ring queue assertion failed");

// next-cycle implication
`define MRQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("message ring queue assertion failed");

`endif

/* rtl/mrq_pkg.sv */
// ----------------------------------------------------------------------------
// mrq_pkg
// types and constants shared by the message ring queue core and its storage
// ----------------------------------------------------------------------------
package mrq_pkg;

    localparam int MAX_SLOTS      = 16;
    localparam int MAX_SLOT_BYTES = 128;
    localparam int HEADER_BYTES   = 32;
    localparam int WORDS_PER_SLOT = (MAX_SLOT_BYTES - HEADER_BYTES) / 8;
    localparam int PAY_DEPTH      = MAX_SLOTS * WORDS_PER_SLOT;

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int WIDX_W = $clog2(WORDS_PER_SLOT + 1);
    localparam int PAY_AW = $clog2(PAY_DEPTH);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [WIDX_W-1:0] widx_t;
    typedef logic [PAY_AW-1:0] pay_addr_t;

    typedef enum logic [1:0] {
        ACT_SEND  = 2'd0,
        ACT_WORD  = 2'd1,
        ACT_FETCH = 2'd2,
        ACT_ACK   = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_TOO_LONG = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_BUSY     = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CFG_RING_SLOTS = 1'b0,
        CFG_SLOT_BYTES = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_HDR,
        FS_WORD
    } fsm_t;

    // one slot header, flags in the low bits
    typedef struct packed {
        logic [63:0] reply_label;
        logic [63:0] label;
        logic [6:0]  length;
        logic [7:0]  reply_endpoint;
        logic [15:0] vpe;
        logic [7:0]  endpoint;
        logic [15:0] core;
        logic [7:0]  flags;
    } hdr_entry_t;

    typedef struct packed {
        logic  we;
        logic  re;
        slot_t waddr;
        slot_t raddr;
    } hdr_ctrl_t;

    typedef struct packed {
        logic  we;
        logic  re;
        slot_t wslot;
        widx_t wword;
        slot_t rslot;
        widx_t rword;
    } pay_ctrl_t;

endpackage

/* rtl/mrq_store.sv */
// ----------------------------------------------------------------------------
// mrq_store
// slot header memory and payload word memory, registered reads
// ----------------------------------------------------------------------------
module mrq_store (
    input  logic                clk,
    input  mrq_pkg::hdr_ctrl_t  hdr_ctrl,
    input  mrq_pkg::hdr_entry_t hdr_wdata,
    output mrq_pkg::hdr_entry_t hdr_rdata,
    input  mrq_pkg::pay_ctrl_t  pay_ctrl,
    input  logic [63:0]         pay_wdata,
    output logic [63:0]         pay_rdata
);

    mrq_pkg::hdr_entry_t hdr_mem [mrq_pkg::MAX_SLOTS];
    logic [63:0]         pay_mem [mrq_pkg::PAY_DEPTH];

    mrq_pkg::pay_addr_t pay_waddr;
    mrq_pkg::pay_addr_t pay_raddr;

    // word address inside the flat payload memory: slot * words + word
    assign pay_waddr = mrq_pkg::PAY_AW'(pay_ctrl.wslot)
                       * mrq_pkg::PAY_AW'(mrq_pkg::WORDS_PER_SLOT)
                       + mrq_pkg::PAY_AW'(pay_ctrl.wword);
    assign pay_raddr = mrq_pkg::PAY_AW'(pay_ctrl.rslot)
                       * mrq_pkg::PAY_AW'(mrq_pkg::WORDS_PER_SLOT)
                       + mrq_pkg::PAY_AW'(pay_ctrl.rword);

    always_ff @(posedge clk)
    begin
        if (hdr_ctrl.we)
        begin
            hdr_mem[hdr_ctrl.waddr] <= hdr_wdata;
        end
        if (hdr_ctrl.re)
        begin
            hdr_rdata <= hdr_mem[hdr_ctrl.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_ctrl.we)
        begin
            pay_mem[pay_waddr] <= pay_wdata;
        end
        if (pay_ctrl.re)
        begin
            pay_rdata <= pay_mem[pay_raddr];
        end
    end

endmodule

/* rtl/message_ring_queue_core.sv */
// ----------------------------------------------------------------------------
// message_ring_queue_core
// single-producer single-consumer ring of message slots with streaming ports
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 carries
//  s_axis    in   s_axis_tvalid/tready      action in tuser, send fields in tdata
//  m_axis    out  m_axis_tvalid/tready      status in tuser, fetch fields, tlast
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  send, payload word and ack: one result word each; with the output taken
//    every cycle they run one per cycle
//  fetch: a header memory read, then 1 + ceil(length/8) result words at one
//    per cycle, paced by the payload memory read port
//  no new word is taken while a fetch is streaming; m_axis_tready low holds
//    the output register and stalls the sequence
//  reset clears pointers and control state; memory contents are not cleared
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module message_ring_queue_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: flags, core, endpoint, vpe, reply endpoint, label,
    //        reply label, length, payload word
    input  logic [255:0] s_axis_tdata,
    // tuser: action
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: out_flags, out_core, out_endpoint, out_vpe, out_reply_endpoint,
    //        out_label, out_reply_label, out_length, out_word, one zero bit
    output logic [255:0] m_axis_tdata,
    // tuser: status
    output logic [2:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    // ring size rounded down to a power of two in 2..16, as an index mask
    function automatic mrq_pkg::slot_t slots_mask(input logic [4:0] v);
        mrq_pkg::slot_t m;
        if (v >= 5'd16)     m = 4'hF;
        else if (v >= 5'd8) m = 4'h7;
        else if (v >= 5'd4) m = 4'h3;
        else                m = 4'h1;
        return m;
    endfunction

    // slot size rounded down to a power of two in 32..128
    function automatic logic [7:0] pow2_slot_bytes(input logic [7:0] v);
        logic [7:0] s;
        if (v >= 8'd128)     s = 8'd128;
        else if (v >= 8'd64) s = 8'd64;
        else                 s = 8'd32;
        return s;
    endfunction

    mrq_pkg::fsm_t       state_reg, state_next;
    mrq_pkg::slot_t      mask_reg, mask_next;
    logic [7:0]          sb_reg, sb_next;
    mrq_pkg::slot_t      head_reg, head_next;
    mrq_pkg::slot_t      tail_reg, tail_next;
    logic                collecting_reg, collecting_next;
    mrq_pkg::widx_t      words_left_reg, words_left_next;
    mrq_pkg::widx_t      wwi_reg, wwi_next;
    logic [6:0]          pend_len_reg, pend_len_next;
    mrq_pkg::widx_t      word_idx_reg, word_idx_next;
    mrq_pkg::widx_t      word_cnt_reg, word_cnt_next;

    logic                out_valid_reg, out_valid_next;
    mrq_pkg::status_t    out_status_reg, out_status_next;
    mrq_pkg::hdr_entry_t out_hdr_reg, out_hdr_next;
    logic [63:0]         out_word_reg, out_word_next;
    logic                out_last_reg, out_last_next;

    mrq_pkg::hdr_ctrl_t  hdr_ctrl;
    mrq_pkg::hdr_entry_t hdr_wdata;
    mrq_pkg::hdr_entry_t hdr_rdata;
    mrq_pkg::pay_ctrl_t  pay_ctrl;
    logic [63:0]         pay_wdata;
    logic [63:0]         pay_rdata;

    logic                out_free;
    logic                in_fire;
    logic                cfg_fire;
    mrq_pkg::act_t       act;
    logic [7:0]          in_len;
    logic [63:0]         in_word;
    mrq_pkg::slot_t      head_inc;
    logic                too_long;
    logic                ring_full;
    logic                ring_empty;
    logic [8:0]          len_round;
    logic [2:0]          rem;
    logic [63:0]         masked_word;
    logic [7:0]          rd_len_round;
    mrq_pkg::widx_t      rd_cnt;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == mrq_pkg::FS_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;

    assign act     = mrq_pkg::act_t'(s_axis_tuser);
    assign in_len  = s_axis_tdata[191:184];
    assign in_word = s_axis_tdata[255:192];

    assign head_inc   = (head_reg + 4'd1) & mask_reg;
    assign too_long   = ({1'b0, in_len} + 9'(mrq_pkg::HEADER_BYTES)) > {1'b0, sb_reg};
    assign ring_full  = (head_inc == tail_reg);
    assign ring_empty = (head_reg == tail_reg);
    assign len_round  = {1'b0, in_len} + 9'd7;

    assign hdr_wdata.flags          = s_axis_tdata[7:0];
    assign hdr_wdata.core           = s_axis_tdata[23:8];
    assign hdr_wdata.endpoint       = s_axis_tdata[31:24];
    assign hdr_wdata.vpe            = s_axis_tdata[47:32];
    assign hdr_wdata.reply_endpoint = s_axis_tdata[55:48];
    assign hdr_wdata.label          = s_axis_tdata[119:56];
    assign hdr_wdata.reply_label    = s_axis_tdata[183:120];
    assign hdr_wdata.length         = in_len[6:0];

    // bytes past the length in the final word are stored as zero
    assign rem = pend_len_reg[2:0];
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            if ((words_left_reg == 4'd1) && (rem != 3'd0) && (3'(b) >= rem))
                masked_word[8*b +: 8] = 8'h00;
            else
                masked_word[8*b +: 8] = in_word[8*b +: 8];
        end
    end
    assign pay_wdata = masked_word;

    // words in the fetched slot, from the header just read
    assign rd_len_round = {1'b0, hdr_rdata.length} + 8'd7;
    assign rd_cnt = (rd_len_round[7:3] > 5'(mrq_pkg::WORDS_PER_SLOT))
                    ? mrq_pkg::WIDX_W'(mrq_pkg::WORDS_PER_SLOT)
                    : rd_len_round[6:3];

    mrq_store u_store (
        .clk       (clk),
        .hdr_ctrl  (hdr_ctrl),
        .hdr_wdata (hdr_wdata),
        .hdr_rdata (hdr_rdata),
        .pay_ctrl  (pay_ctrl),
        .pay_wdata (pay_wdata),
        .pay_rdata (pay_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        mask_next       = mask_reg;
        sb_next         = sb_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        collecting_next = collecting_reg;
        words_left_next = words_left_reg;
        wwi_next        = wwi_reg;
        pend_len_next   = pend_len_reg;
        word_idx_next   = word_idx_reg;
        word_cnt_next   = word_cnt_reg;

        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_hdr_next    = out_hdr_reg;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;

        hdr_ctrl.we    = 1'b0;
        hdr_ctrl.re    = 1'b0;
        hdr_ctrl.waddr = head_reg;
        hdr_ctrl.raddr = tail_reg;
        pay_ctrl.we    = 1'b0;
        pay_ctrl.re    = 1'b0;
        pay_ctrl.wslot = head_reg;
        pay_ctrl.wword = wwi_reg;
        pay_ctrl.rslot = tail_reg;
        pay_ctrl.rword = '0;

        case (state_reg)
            mrq_pkg::FS_IDLE:
            begin
                if (in_fire)
                begin
                    // single-word results share these values
                    out_valid_next  = 1'b1;
                    out_status_next = mrq_pkg::STAT_OK;
                    out_hdr_next    = '0;
                    out_word_next   = '0;
                    out_last_next   = 1'b1;
                    case (act)
                        mrq_pkg::ACT_SEND:
                        begin
                            if (collecting_reg)
                                out_status_next = mrq_pkg::STAT_BUSY;
                            else if (too_long)
                                out_status_next = mrq_pkg::STAT_TOO_LONG;
                            else if (ring_full)
                                out_status_next = mrq_pkg::STAT_FULL;
                            else
                            begin
                                hdr_ctrl.we     = 1'b1;
                                pend_len_next   = in_len[6:0];
                                words_left_next = len_round[6:3];
                                wwi_next        = '0;
                                if (len_round[6:3] == 4'd0)
                                    head_next = head_inc;
                                else
                                    collecting_next = 1'b1;
                            end
                        end
                        mrq_pkg::ACT_WORD:
                        begin
                            if (!collecting_reg || (words_left_reg == 4'd0) ||
                                (wwi_reg >= mrq_pkg::WIDX_W'(mrq_pkg::WORDS_PER_SLOT)))
                                out_status_next = mrq_pkg::STAT_BUSY;
                            else
                            begin
                                pay_ctrl.we     = 1'b1;
                                wwi_next        = wwi_reg + 4'd1;
                                words_left_next = words_left_reg - 4'd1;
                                if (words_left_reg == 4'd1)
                                begin
                                    collecting_next = 1'b0;
                                    head_next       = head_inc;
                                end
                            end
                        end
                        mrq_pkg::ACT_FETCH:
                        begin
                            if (ring_empty)
                                out_status_next = mrq_pkg::STAT_EMPTY;
                            else
                            begin
                                // header and first word read together
                                out_valid_next = out_valid_reg && !m_axis_tready;
                                hdr_ctrl.re    = 1'b1;
                                pay_ctrl.re    = 1'b1;
                                state_next     = mrq_pkg::FS_HDR;
                            end
                        end
                        mrq_pkg::ACT_ACK:
                        begin
                            if (ring_empty)
                                out_status_next = mrq_pkg::STAT_EMPTY;
                            else
                                tail_next = (tail_reg + 4'd1) & mask_reg;
                        end
                        default:
                        begin
                            out_status_next = mrq_pkg::STAT_BUSY;
                        end
                    endcase
                end
            end
            mrq_pkg::FS_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = mrq_pkg::STAT_OK;
                    out_hdr_next    = hdr_rdata;
                    out_word_next   = '0;
                    out_last_next   = (rd_cnt == 4'd0);
                    word_cnt_next   = rd_cnt;
                    word_idx_next   = '0;
                    state_next      = (rd_cnt == 4'd0) ? mrq_pkg::FS_IDLE : mrq_pkg::FS_WORD;
                end
            end
            mrq_pkg::FS_WORD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = mrq_pkg::STAT_OK;
                    out_hdr_next    = hdr_rdata;
                    out_word_next   = pay_rdata;
                    out_last_next   = ((word_idx_reg + 4'd1) == word_cnt_reg);
                    word_idx_next   = word_idx_reg + 4'd1;
                    if ((word_idx_reg + 4'd1) == word_cnt_reg)
                        state_next = mrq_pkg::FS_IDLE;
                    else
                    begin
                        pay_ctrl.re    = 1'b1;
                        pay_ctrl.rword = word_idx_reg + 4'd1;
                    end
                end
            end
            default:
            begin
                state_next = mrq_pkg::FS_IDLE;
            end
        endcase

        if (cfg_fire)
        begin
            case (mrq_pkg::cfg_idx_t'(cfg_index))
                mrq_pkg::CFG_RING_SLOTS:
                begin
                    mask_next       = slots_mask(cfg_data[4:0]);
                    head_next       = '0;
                    tail_next       = '0;
                    collecting_next = 1'b0;
                    words_left_next = '0;
                    wwi_next        = '0;
                    pend_len_next   = '0;
                end
                mrq_pkg::CFG_SLOT_BYTES:
                begin
                    sb_next = pow2_slot_bytes(cfg_data);
                end
                default:
                begin
                    sb_next = sb_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mrq_pkg::FS_IDLE;
            mask_reg       <= 4'hF;
            sb_reg         <= 8'd128;
            head_reg       <= '0;
            tail_reg       <= '0;
            collecting_reg <= 1'b0;
            words_left_reg <= '0;
            wwi_reg        <= '0;
            pend_len_reg   <= '0;
            word_idx_reg   <= '0;
            word_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mask_reg       <= mask_next;
            sb_reg         <= sb_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            collecting_reg <= collecting_next;
            words_left_reg <= words_left_next;
            wwi_reg        <= wwi_next;
            pend_len_reg   <= pend_len_next;
            word_idx_reg   <= word_idx_next;
            word_cnt_reg   <= word_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_hdr_reg    <= out_hdr_next;
        out_word_reg   <= out_word_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_word_reg, out_hdr_reg.length,
                            out_hdr_reg.reply_label, out_hdr_reg.label,
                            out_hdr_reg.reply_endpoint, out_hdr_reg.vpe,
                            out_hdr_reg.endpoint, out_hdr_reg.core,
                            out_hdr_reg.flags};

    `MRQ_ASSERT_IMP(a_collect_has_words, collecting_reg, words_left_reg != 4'd0)
    `MRQ_ASSERT_IMP(a_ptrs_in_ring, 1'b1,
        ((head_reg & ~mask_reg) == 4'd0) && ((tail_reg & ~mask_reg) == 4'd0))
    `MRQ_ASSERT_IMP(a_word_idx_bound, state_reg == mrq_pkg::FS_WORD,
        (word_cnt_reg != 4'd0) && (word_idx_reg < word_cnt_reg))
    `MRQ_ASSERT_NXT(a_fetch_starts, in_fire && (act == mrq_pkg::ACT_FETCH) && !ring_empty
        && !cfg_fire, state_reg == mrq_pkg::FS_HDR)

endmodule
